### src/snm_pkg.sv
// ----------------------------------------------------------------------------
// snm_pkg
// Shared types and constants of the height-to-normal-map converter.
// ----------------------------------------------------------------------------
package snm_pkg;

   // input item codes
   localparam logic OPC_PIXEL = 1'b0;
   localparam logic OPC_FLUSH = 1'b1;

   // register port
   localparam int CSR_AW = 2;
   localparam int CSR_DW = 16;
   localparam logic [CSR_AW-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_NORMAL_Z     = 2'd2;

   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int SUM_W        = 10;
   localparam int BYTE_W       = 8;
   localparam int POS_COL_W    = 10;
   localparam int POS_ROW_W    = 12;

   // shared multiplier operand widths
   localparam int MUL_AW = 33;
   localparam int MUL_BW = 17;
   localparam int MUL_PW = MUL_AW + MUL_BW;

   // 255 squared
   localparam logic [MUL_BW-1:0] BYTE_SCALE_SQ = 17'd65025;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_SHIFT,
      DP_SQ_GX,
      DP_SQ_GY,
      DP_SQ_Z,
      DP_LEN,
      DP_RHS,
      DP_RHS_LD,
      DP_ASQ,
      DP_ALEN,
      DP_CMP,
      DP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type              op;
      logic                   load;
      logic                   mem_we;
      logic                   complete;
      logic                   row_one;
      logic                   parity;
      logic                   pre;
      logic [1:0]             left_sel;
      logic [1:0]             comp;
      logic [2:0]             bitn;
      logic [POS_COL_W-1:0]   pos_col;
      logic [POS_ROW_W-1:0]   pos_row;
      logic                   frame_done;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_stat_type;

endpackage

### src/sobel_normal_map.sv
// ----------------------------------------------------------------------------
// sobel_normal_map
// Raster RGB in, Sobel normal-map bytes out, one row and one pixel behind.
// ----------------------------------------------------------------------------
// an item that yields no result holds the input through the window shift; a flush
//   dropped inside the frame is taken without leaving idle
// an item that yields a result holds it through the work: one shared 33x17
//   multiplier does the squares, then each bit of the 8-bit search squares the
//   trial, scales it by the length and compares it, for each of the three components;
//   the result is loaded once the output register is free, which lets the next beat in while a result waits
// synchronous reset clears counters and handshake; the line store is not cleared
module sobel_normal_map #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_opcode,
   input  logic [7:0]                    req_red_in,
   input  logic [7:0]                    req_green_in,
   input  logic [7:0]                    req_blue_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [7:0]                    rsp_normal_x_byte,
   output logic [7:0]                    rsp_normal_y_byte,
   output logic [7:0]                    rsp_normal_z_byte,
   output logic [snm_pkg::POS_COL_W-1:0] rsp_out_col,
   output logic [snm_pkg::POS_ROW_W-1:0] rsp_out_row,
   output logic                          rsp_frame_done,
   input  logic                          csr_wen,
   input  logic [snm_pkg::CSR_AW-1:0]    csr_addr,
   input  logic [snm_pkg::CSR_DW-1:0]    csr_wdata
);
   import snm_pkg::*;

   localparam int WID_W = $clog2(MAX_WIDTH + 1);
   localparam int HGT_W = $clog2(MAX_HEIGHT + 1);
   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int W_RST = (MAX_WIDTH < 640) ? MAX_WIDTH : 640;
   localparam int H_RST = (MAX_HEIGHT < 480) ? MAX_HEIGHT : 480;

   logic [WID_W-1:0]  width_ff, width_in;
   logic [HGT_W-1:0]  height_ff, height_in;
   logic [CSR_DW-1:0] z_ff, z_in;
   logic              restart;
   logic [WID_W+WIDTH_REG_W-1:0]  w_ext;
   logic [HGT_W+HEIGHT_REG_W-1:0] h_ext;

   dp_cmd_type       cmd;
   dp_stat_type      stat;
   logic [COL_W-1:0] col_addr;

   // dimensions are kept already clamped to 1..max
   always_comb begin
      w_ext     = (WID_W + WIDTH_REG_W)'(csr_wdata[WIDTH_REG_W-1:0]);
      h_ext     = (HGT_W + HEIGHT_REG_W)'(csr_wdata[HEIGHT_REG_W-1:0]);
      width_in  = width_ff;
      height_in = height_ff;
      z_in      = z_ff;
      restart   = 1'b0;
      if (csr_wen) begin
         unique case (csr_addr)
            CSR_IMAGE_WIDTH: begin
               restart = 1'b1;
               if (w_ext == '0) begin
                  width_in = WID_W'(1);
               end else if (w_ext > (WID_W + WIDTH_REG_W)'(MAX_WIDTH)) begin
                  width_in = WID_W'(MAX_WIDTH);
               end else begin
                  width_in = w_ext[WID_W-1:0];
               end
            end
            CSR_IMAGE_HEIGHT: begin
               restart = 1'b1;
               if (h_ext == '0) begin
                  height_in = HGT_W'(1);
               end else if (h_ext > (HGT_W + HEIGHT_REG_W)'(MAX_HEIGHT)) begin
                  height_in = HGT_W'(MAX_HEIGHT);
               end else begin
                  height_in = h_ext[HGT_W-1:0];
               end
            end
            CSR_NORMAL_Z: z_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WID_W'(W_RST);
         height_ff <= HGT_W'(H_RST);
         z_ff      <= CSR_DW'(765);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         z_ff      <= z_in;
      end
   end

   snm_ctrl #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_opcode  (req_opcode),
      .cfg_width   (width_ff),
      .cfg_height  (height_ff),
      .cfg_restart (restart),
      .cmd         (cmd),
      .col_addr    (col_addr),
      .stat        (stat)
   );

   snm_datapath #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .col_addr          (col_addr),
      .stat              (stat),
      .cfg_z             (z_ff),
      .req_red_in        (req_red_in),
      .req_green_in      (req_green_in),
      .req_blue_in       (req_blue_in),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_normal_x_byte (rsp_normal_x_byte),
      .rsp_normal_y_byte (rsp_normal_y_byte),
      .rsp_normal_z_byte (rsp_normal_z_byte),
      .rsp_out_col       (rsp_out_col),
      .rsp_out_row       (rsp_out_row),
      .rsp_frame_done    (rsp_frame_done)
   );

endmodule

### src/snm_ctrl.sv
// ----------------------------------------------------------------------------
// snm_ctrl
// Sequencer: position counters, edge decisions and the step order of the
// gradient, normalisation and byte search in the datapath.
// ----------------------------------------------------------------------------
module snm_ctrl #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096,
   localparam int WID_W  = $clog2(MAX_WIDTH + 1),
   localparam int HGT_W  = $clog2(MAX_HEIGHT + 1),
   localparam int COL_W  = $clog2(MAX_WIDTH)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_opcode,
   input  logic [WID_W-1:0]    cfg_width,
   input  logic [HGT_W-1:0]    cfg_height,
   input  logic                cfg_restart,
   output snm_pkg::dp_cmd_type cmd,
   output logic [COL_W-1:0]    col_addr,
   input  snm_pkg::dp_stat_type stat
);
   import snm_pkg::*;

   localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);
   localparam int EROW_W = $clog2(MAX_HEIGHT);

   typedef enum logic [3:0] {
      S_IDLE, S_SHIFT, S_SQ_GX, S_SQ_GY, S_SQ_Z, S_LEN,
      S_RHS, S_RHS_LD, S_ASQ, S_ALEN, S_CMP, S_OUT
   } state_type;

   state_type           state_ff, state_in;
   logic                emit_ff, emit_in;
   logic [1:0]          comp_ff, comp_in;
   logic [2:0]          bit_ff, bit_in;
   logic [COL_W-1:0]    in_col_ff, in_col_in;
   logic [ROW_W-1:0]    in_row_ff, in_row_in;
   logic [COL_W-1:0]    em_col_ff, em_col_in;
   logic [EROW_W-1:0]   em_row_ff, em_row_in;

   logic                accept, complete, drop, emitting, pre, done;
   logic                col_last, em_col_last;
   logic [ROW_W-1:0]    h_row;
   logic [COL_W+POS_COL_W-1:0] col_pad;
   logic [EROW_W+POS_ROW_W-1:0] row_pad;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign col_addr  = in_col_ff;

   always_comb begin
      h_row       = ROW_W'(cfg_height);
      complete    = in_row_ff >= h_row;
      drop        = !complete && (req_opcode == OPC_FLUSH);
      col_last    = WID_W'(in_col_ff) == (cfg_width - WID_W'(1));
      em_col_last = WID_W'(em_col_ff) == (cfg_width - WID_W'(1));
      // centre index lies in 0 .. w*h-1 behind the input by one row and a pixel
      emitting    = ((in_row_ff >= ROW_W'(2)) ||
                     ((in_row_ff == ROW_W'(1)) && (in_col_ff != '0))) &&
                    ((in_row_ff <= h_row) ||
                     ((in_row_ff == h_row + ROW_W'(1)) && (in_col_ff == '0)));
      pre         = em_col_last;
      done        = em_col_last &&
                    (HGT_W'(em_row_ff) == (cfg_height - HGT_W'(1)));
      col_pad     = (COL_W + POS_COL_W)'(em_col_ff);
      row_pad     = (EROW_W + POS_ROW_W)'(em_row_ff);
   end

   always_comb begin
      state_in  = state_ff;
      emit_in   = emit_ff;
      comp_in   = comp_ff;
      bit_in    = bit_ff;
      in_col_in = in_col_ff;
      in_row_in = in_row_ff;
      em_col_in = em_col_ff;
      em_row_in = em_row_ff;

      cmd            = '0;
      cmd.op         = DP_NOP;
      cmd.comp       = comp_ff;
      cmd.bitn       = bit_ff;
      cmd.complete   = complete;
      cmd.row_one    = (in_row_ff == ROW_W'(1));
      cmd.parity     = in_row_ff[0];
      cmd.pre        = pre;
      cmd.pos_col    = col_pad[POS_COL_W-1:0];
      cmd.pos_row    = row_pad[POS_ROW_W-1:0];
      cmd.frame_done = done;
      if (pre) begin
         cmd.left_sel = (cfg_width == WID_W'(1)) ? 2'd2 : 2'd1;
      end else begin
         cmd.left_sel = (em_col_ff == '0) ? 2'd1 : 2'd0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept && !drop) begin
               cmd.load   = 1'b1;
               cmd.mem_we = !complete;
               emit_in    = emitting;
               state_in   = S_SHIFT;
               if (col_last) begin
                  in_col_in = '0;
                  in_row_in = in_row_ff + ROW_W'(1);
               end else begin
                  in_col_in = in_col_ff + COL_W'(1);
               end
               if (emitting) begin
                  if (em_col_last) begin
                     em_col_in = '0;
                     em_row_in = em_row_ff + EROW_W'(1);
                  end else begin
                     em_col_in = em_col_ff + COL_W'(1);
                  end
                  // frame wrap
                  if (done) begin
                     in_col_in = '0;
                     in_row_in = '0;
                     em_col_in = '0;
                     em_row_in = '0;
                  end
               end
            end
         end
         S_SHIFT: begin
            cmd.op   = DP_SHIFT;
            state_in = emit_ff ? S_SQ_GX : S_IDLE;
         end
         S_SQ_GX: begin
            cmd.op   = DP_SQ_GX;
            state_in = S_SQ_GY;
         end
         S_SQ_GY: begin
            cmd.op   = DP_SQ_GY;
            state_in = S_SQ_Z;
         end
         S_SQ_Z: begin
            cmd.op   = DP_SQ_Z;
            state_in = S_LEN;
         end
         S_LEN: begin
            cmd.op   = DP_LEN;
            comp_in  = 2'd0;
            state_in = S_RHS;
         end
         S_RHS: begin
            cmd.op   = DP_RHS;
            state_in = S_RHS_LD;
         end
         S_RHS_LD: begin
            cmd.op   = DP_RHS_LD;
            bit_in   = 3'd7;
            state_in = S_ASQ;
         end
         S_ASQ: begin
            cmd.op   = DP_ASQ;
            state_in = S_ALEN;
         end
         S_ALEN: begin
            cmd.op   = DP_ALEN;
            state_in = S_CMP;
         end
         S_CMP: begin
            cmd.op = DP_CMP;
            if (bit_ff == 3'd0) begin
               if (comp_ff == 2'd2) begin
                  state_in = S_OUT;
               end else begin
                  comp_in  = comp_ff + 2'd1;
                  state_in = S_RHS;
               end
            end else begin
               bit_in   = bit_ff - 3'd1;
               state_in = S_ASQ;
            end
         end
         S_OUT: begin
            if (stat.out_free) begin
               cmd.op   = DP_EMIT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // dimension change restarts the frame
      if (cfg_restart) begin
         in_col_in = '0;
         in_row_in = '0;
         em_col_in = '0;
         em_row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         emit_ff   <= 1'b0;
         comp_ff   <= '0;
         bit_ff    <= '0;
         in_col_ff <= '0;
         in_row_ff <= '0;
         em_col_ff <= '0;
         em_row_ff <= '0;
      end else begin
         state_ff  <= state_in;
         emit_ff   <= emit_in;
         comp_ff   <= comp_in;
         bit_ff    <= bit_in;
         in_col_ff <= in_col_in;
         in_row_ff <= in_row_in;
         em_col_ff <= em_col_in;
         em_row_ff <= em_row_in;
      end
   end

endmodule

### src/snm_datapath.sv
// ----------------------------------------------------------------------------
// snm_datapath
// Line store, 3x3 window, Sobel terms, shared multiplier, bitwise byte
// search and the result register.
// ----------------------------------------------------------------------------
module snm_datapath #(
   parameter int MAX_WIDTH = 1024,
   localparam int COL_W = $clog2(MAX_WIDTH)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  snm_pkg::dp_cmd_type           cmd,
   input  logic [COL_W-1:0]              col_addr,
   output snm_pkg::dp_stat_type          stat,
   input  logic [snm_pkg::CSR_DW-1:0]    cfg_z,
   input  logic [7:0]                    req_red_in,
   input  logic [7:0]                    req_green_in,
   input  logic [7:0]                    req_blue_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [7:0]                    rsp_normal_x_byte,
   output logic [7:0]                    rsp_normal_y_byte,
   output logic [7:0]                    rsp_normal_z_byte,
   output logic [snm_pkg::POS_COL_W-1:0] rsp_out_col,
   output logic [snm_pkg::POS_ROW_W-1:0] rsp_out_row,
   output logic                          rsp_frame_done
);
   import snm_pkg::*;

   localparam int MEM_AW    = COL_W + 1;
   localparam int MEM_DEPTH = 2 ** MEM_AW;

   // line store, two row slots picked by row parity
   logic [SUM_W-1:0]  mem [MEM_DEPTH];
   logic [SUM_W-1:0]  top_rd_ff, mid_rd_ff;
   logic [MEM_AW-1:0] addr_top, addr_mid;
   logic [SUM_W-1:0]  sum_in;

   // item held over the work
   logic [SUM_W-1:0]     s_ff;
   logic                 complete_ff, row_one_ff, pre_ff, done_ff;
   logic [1:0]           left_ff;
   logic [POS_COL_W-1:0] col_ff;
   logic [POS_ROW_W-1:0] row_ff;

   logic [SUM_W-1:0] win_ff [3][3];
   logic [SUM_W-1:0] sh [3][3];
   logic [SUM_W-1:0] vw [3][3];
   logic [SUM_W-1:0] t_l, t_c, t_r, m_l, m_r, b_l, b_c, b_r;
   logic [1:0]       c_sel;
   logic [11:0]      tsum, bsum, lsum, rsum;

   logic signed [12:0] gx_ff, gy_ff;
   logic [12:0]        gx_abs, gy_abs;
   logic [15:0]        z_eff;

   logic [MUL_AW-1:0] mul_a;
   logic [MUL_BW-1:0] mul_b;
   logic [MUL_PW-1:0] mul_p, prod_ff;
   logic [31:0]       sqx_ff, sqy_ff, sqz_ff, sq_sel;
   logic [32:0]       len2_ff;
   logic [47:0]       rhs_ff;

   logic [7:0] k_ff, trial, k_next, amag, bit_mask;
   logic       c_neg, ok;
   logic [7:0] bx_ff, by_ff, bz_ff;
   logic       rsp_valid_ff;

   function automatic logic [SUM_W-1:0] pick3(input logic [SUM_W-1:0] a0,
                                              input logic [SUM_W-1:0] a1,
                                              input logic [SUM_W-1:0] a2,
                                              input logic [1:0] sel);
      logic [SUM_W-1:0] r;
      unique case (sel)
         2'd0:    r = a0;
         2'd1:    r = a1;
         default: r = a2;
      endcase
      return r;
   endfunction

   assign sum_in   = SUM_W'(req_red_in) + SUM_W'(req_green_in) + SUM_W'(req_blue_in);
   assign addr_top = {cmd.parity, col_addr};
   assign addr_mid = {~cmd.parity, col_addr};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         top_rd_ff <= mem[addr_top];
         mid_rd_ff <= mem[addr_mid];
         if (cmd.mem_we) begin
            mem[addr_top] <= sum_in;
         end
      end
   end

   // window after taking in the new column
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sh[i][0] = win_ff[i][1];
         sh[i][1] = win_ff[i][2];
      end
      sh[0][2] = row_one_ff ? mid_rd_ff : top_rd_ff;
      sh[1][2] = mid_rd_ff;
      sh[2][2] = complete_ff ? mid_rd_ff : s_ff;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            vw[i][j] = pre_ff ? win_ff[i][j] : sh[i][j];
         end
      end
      c_sel = pre_ff ? 2'd2 : 2'd1;
      t_l = pick3(vw[0][0], vw[0][1], vw[0][2], left_ff);
      m_l = pick3(vw[1][0], vw[1][1], vw[1][2], left_ff);
      b_l = pick3(vw[2][0], vw[2][1], vw[2][2], left_ff);
      t_c = pick3(vw[0][0], vw[0][1], vw[0][2], c_sel);
      b_c = pick3(vw[2][0], vw[2][1], vw[2][2], c_sel);
      t_r = vw[0][2];
      m_r = vw[1][2];
      b_r = vw[2][2];
      // row below minus row above, left column minus right
      bsum = 12'(b_l) + {1'b0, b_c, 1'b0} + 12'(b_r);
      tsum = 12'(t_l) + {1'b0, t_c, 1'b0} + 12'(t_r);
      lsum = 12'(t_l) + {1'b0, m_l, 1'b0} + 12'(b_l);
      rsum = 12'(t_r) + {1'b0, m_r, 1'b0} + 12'(b_r);
   end

   assign gx_abs = gx_ff[12] ? (13'd0 - gx_ff) : gx_ff;
   assign gy_abs = gy_ff[12] ? (13'd0 - gy_ff) : gy_ff;
   assign z_eff  = (cfg_z == '0) ? 16'd1 : cfg_z;

   // |2k - 255| of the trial byte
   assign bit_mask = 8'd1 << cmd.bitn;
   assign trial    = k_ff | bit_mask;
   assign amag     = trial[7] ? {trial[6:0], 1'b1} : ~{trial[6:0], 1'b0};

   always_comb begin
      unique case (cmd.comp)
         2'd0:    begin sq_sel = sqx_ff; c_neg = gx_ff[12]; end
         2'd1:    begin sq_sel = sqy_ff; c_neg = gy_ff[12]; end
         default: begin sq_sel = sqz_ff; c_neg = 1'b0;      end
      endcase
      if (!trial[7]) begin
         ok = !c_neg || (prod_ff >= MUL_PW'(rhs_ff));
      end else begin
         ok = !c_neg && (prod_ff <= MUL_PW'(rhs_ff));
      end
      k_next = ok ? trial : k_ff;
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.op)
         DP_SQ_GX: begin mul_a = MUL_AW'(gx_abs); mul_b = MUL_BW'(gx_abs); end
         DP_SQ_GY: begin mul_a = MUL_AW'(gy_abs); mul_b = MUL_BW'(gy_abs); end
         DP_SQ_Z:  begin mul_a = MUL_AW'(z_eff);  mul_b = MUL_BW'(z_eff);  end
         DP_RHS:   begin mul_a = MUL_AW'(sq_sel); mul_b = BYTE_SCALE_SQ;   end
         DP_ASQ:   begin mul_a = MUL_AW'(amag);   mul_b = MUL_BW'(amag);   end
         DP_ALEN:  begin mul_a = len2_ff;         mul_b = prod_ff[MUL_BW-1:0]; end
         default:  begin mul_a = '0;              mul_b = '0;              end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         s_ff        <= sum_in;
         complete_ff <= cmd.complete;
         row_one_ff  <= cmd.row_one;
         pre_ff      <= cmd.pre;
         left_ff     <= cmd.left_sel;
         col_ff      <= cmd.pos_col;
         row_ff      <= cmd.pos_row;
         done_ff     <= cmd.frame_done;
      end
      unique case (cmd.op)
         DP_SHIFT: begin
            gx_ff  <= $signed({1'b0, bsum}) - $signed({1'b0, tsum});
            gy_ff  <= $signed({1'b0, lsum}) - $signed({1'b0, rsum});
            win_ff <= sh;
         end
         DP_SQ_GX, DP_ASQ, DP_ALEN: begin
            prod_ff <= mul_p;
         end
         DP_SQ_GY: begin
            sqx_ff  <= prod_ff[31:0];
            prod_ff <= mul_p;
         end
         DP_SQ_Z: begin
            sqy_ff  <= prod_ff[31:0];
            prod_ff <= mul_p;
         end
         DP_LEN: begin
            sqz_ff  <= prod_ff[31:0];
            len2_ff <= 33'(sqx_ff) + 33'(sqy_ff) + prod_ff[32:0];
         end
         DP_RHS: begin
            prod_ff <= mul_p;
            k_ff    <= '0;
         end
         DP_RHS_LD: begin
            rhs_ff <= prod_ff[47:0];
         end
         DP_CMP: begin
            k_ff <= k_next;
            if (cmd.bitn == 3'd0) begin
               unique case (cmd.comp)
                  2'd0:    bx_ff <= k_next;
                  2'd1:    by_ff <= k_next;
                  default: bz_ff <= k_next;
               endcase
            end
         end
         DP_EMIT: begin
            rsp_normal_x_byte <= bx_ff;
            rsp_normal_y_byte <= by_ff;
            rsp_normal_z_byte <= bz_ff;
            rsp_out_col       <= col_ff;
            rsp_out_row       <= row_ff;
            rsp_frame_done    <= done_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == DP_EMIT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

endmodule

### tb/sobel_normal_map_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_normal_map_test
// Drives raster frames of RGB pixels and flush beats into the normal-map
// converter with random idling on both channels, predicts every normal from
// its own line store and 3x3 window, and checks every field of each result.
// ----------------------------------------------------------------------------
module sobel_normal_map_test;
   import snm_pkg::*;

   localparam int LINE_MAX   = 1024;
   localparam int ROWS_MAX   = 4096;
   localparam int CYCLE_CAP  = 3_000_000;
   localparam int SETTLE     = 120;
   localparam int CUT_MAX    = 40;

   typedef struct packed {
      logic [7:0]  nx;
      logic [7:0]  ny;
      logic [7:0]  nz;
      logic [9:0]  col;
      logic [11:0] row;
      logic        done;
   } normal_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_opcode = OPC_PIXEL;
   logic [7:0]           req_red_in = '0;
   logic [7:0]           req_green_in = '0;
   logic [7:0]           req_blue_in = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [7:0]           rsp_normal_x_byte;
   logic [7:0]           rsp_normal_y_byte;
   logic [7:0]           rsp_normal_z_byte;
   logic [POS_COL_W-1:0] rsp_out_col;
   logic [POS_ROW_W-1:0] rsp_out_row;
   logic                 rsp_frame_done;
   logic                 csr_wen = 1'b0;
   logic [CSR_AW-1:0]    csr_addr = CSR_IMAGE_WIDTH;
   logic [CSR_DW-1:0]    csr_wdata = '0;

   sobel_normal_map dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   int unsigned width_reg = 640, height_reg = 480, zterm_reg = 765;
   logic [9:0]  line_sums [0:2*LINE_MAX-1];
   int unsigned win [3][3];
   int unsigned in_col, in_row, em_col, em_row;
   bit          frame_closed;
   bit          quiet;
   normal_type  normals_due [$];
   int          errors, normals_checked, beats_sent, frames_done, cycles;

   function automatic int unsigned eff_width();
      return width_reg < 1 ? 1 : (width_reg > LINE_MAX ? LINE_MAX : width_reg);
   endfunction

   function automatic int unsigned eff_height();
      return height_reg < 1 ? 1 : (height_reg > ROWS_MAX ? ROWS_MAX : height_reg);
   endfunction

   // (2k-255)*L <= 255*c without a square root, L*L = len2
   function automatic bit byte_fits(int k, longint c, longint len2);
      longint a, a2, cm, rhs;
      a   = 2 * k - 255;
      a2  = a * a;
      cm  = c < 0 ? -c : c;
      rhs = 65025 * cm * cm;
      if (a <= 0) return (c >= 0) ? 1'b1 : (a2 * len2 >= rhs);
      if (c < 0) return 1'b0;
      return a2 * len2 <= rhs;
   endfunction

   function automatic logic [7:0] to_byte(longint c, longint len2);
      int lo, hi, mid;
      lo = 0;
      hi = 255;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         if (byte_fits(mid, c, len2)) lo = mid;
         else hi = mid - 1;
      end
      return lo[7:0];
   endfunction

   function automatic normal_type centre_normal(int l, int c, int r);
      normal_type  n;
      longint      gx, gy, z, len2;
      int unsigned w, h;
      w  = eff_width();
      h  = eff_height();
      gx = longint'(win[2][l]) + 2 * win[2][c] + win[2][r]
         - win[0][l] - 2 * win[0][c] - win[0][r];
      gy = longint'(win[0][l]) + 2 * win[1][l] + win[2][l]
         - win[0][r] - 2 * win[1][r] - win[2][r];
      z  = zterm_reg == 0 ? 1 : zterm_reg;
      len2 = gx * gx + gy * gy + z * z;
      n.nx   = to_byte(gx, len2);
      n.ny   = to_byte(gy, len2);
      n.nz   = to_byte(z, len2);
      n.col  = em_col[9:0];
      n.row  = em_row[11:0];
      n.done = (em_row * w + em_col == w * h - 1);
      return n;
   endfunction

   task automatic predict(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int unsigned w, h, p, ic, ir, s, top, mid, bot;
      bit          complete, emitting, got;
      normal_type  res;
      w  = eff_width();
      h  = eff_height();
      p  = in_row * w + in_col;
      complete = in_row >= h;
      ic = in_col < w ? in_col : w - 1;
      ir = in_row;
      got = 1'b0;
      if (!complete && op == OPC_FLUSH) return;
      s = complete ? 0 : int'(r) + g + b;
      emitting = (p >= w + 1) && (p - w - 1 < w * h);
      if (emitting && em_col == w - 1) begin
         res = centre_normal(w == 1 ? 2 : 1, 2, 2);
         got = 1'b1;
      end
      top = line_sums[(ir & 1) * LINE_MAX + ic];
      mid = line_sums[((ir + 1) & 1) * LINE_MAX + ic];
      if (ir == 1) top = mid;
      bot = complete ? mid : s;
      if (!complete) line_sums[(ir & 1) * LINE_MAX + ic] = s[9:0];
      for (int i = 0; i < 3; i++) begin
         win[i][0] = win[i][1];
         win[i][1] = win[i][2];
      end
      win[0][2] = top;
      win[1][2] = mid;
      win[2][2] = bot;
      if (emitting && !got) begin
         res = centre_normal(em_col == 0 ? 1 : 0, 1, 2);
         got = 1'b1;
      end
      in_col++;
      if (in_col >= w) begin
         in_col = 0;
         in_row++;
      end
      if (got) begin
         normals_due.push_back(res);
         em_col++;
         if (em_col >= w) begin
            em_col = 0;
            em_row++;
         end
         if (res.done) begin
            in_col = 0; in_row = 0; em_col = 0; em_row = 0;
            frame_closed = 1'b1;
            frames_done++;
         end
      end
   endtask

   // one beat on the request side, accepted before return
   task automatic send_beat(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_opcode   <= op;
      req_red_in   <= r;
      req_green_in <= g;
      req_blue_in  <= b;
      do @(posedge clock); while (!req_ready);
      predict(op, r, g, b);
      beats_sent++;
   endtask

   task automatic send_pixel();
      send_beat(OPC_PIXEL, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)));
   endtask

   // register writes only once the block has gone quiet
   task automatic write_reg(logic [CSR_AW-1:0] idx, int unsigned val);
      req_valid <= 1'b0;
      while (normals_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_wen   <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val[CSR_DW-1:0];
      @(posedge clock);
      csr_wen   <= 1'b0;
      case (idx)
         CSR_IMAGE_WIDTH: begin
            width_reg = val & 'h7FF;
            in_col = 0; in_row = 0; em_col = 0; em_row = 0;
         end
         CSR_IMAGE_HEIGHT: begin
            height_reg = val & 'h1FFF;
            in_col = 0; in_row = 0; em_col = 0; em_row = 0;
         end
         CSR_NORMAL_Z: zterm_reg = val & 'hFFFF;
         default: ;
      endcase
   endtask

   // drain items until the frame's last normal is predicted
   task automatic drain_frame();
      while (!frame_closed) begin
         if ($urandom_range(0, 4) == 0) send_pixel();
         else send_beat(OPC_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
      end
   endtask

   task automatic run_frame(int unsigned w, int unsigned h, bit cut_short);
      int unsigned total, stop_at;
      write_reg(CSR_IMAGE_WIDTH, w);
      write_reg(CSR_IMAGE_HEIGHT, h);
      frame_closed = 1'b0;
      total   = eff_width() * eff_height();
      // a cut frame stops early and is restarted by the next size write
      stop_at = cut_short ? $urandom_range(0, (total > CUT_MAX ? CUT_MAX : total) - 1)
                          : total;
      for (int unsigned i = 0; i < stop_at; i++) begin
         if ($urandom_range(0, 9) == 0)
            send_beat(OPC_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
         send_pixel();
      end
      if (!cut_short) drain_frame();
   endtask

   task automatic test_small_frame();
      write_reg(CSR_IMAGE_WIDTH, 3);
      write_reg(CSR_IMAGE_HEIGHT, 3);
      frame_closed = 1'b0;
      send_beat(OPC_PIXEL, 8'hFF, 8'hFF, 8'hFF);
      send_beat(OPC_PIXEL, 8'h00, 8'h00, 8'h00);
      // flush inside the frame is dropped
      send_beat(OPC_FLUSH, 8'h12, 8'h34, 8'h56);
      send_beat(OPC_PIXEL, 8'hFF, 8'h00, 8'hFF);
      send_beat(OPC_PIXEL, 8'h00, 8'hFF, 8'h00);
      send_beat(OPC_PIXEL, 8'hAA, 8'h55, 8'hAA);
      send_beat(OPC_PIXEL, 8'h55, 8'hAA, 8'h55);
      send_beat(OPC_PIXEL, 8'hFF, 8'hFF, 8'hFF);
      send_beat(OPC_PIXEL, 8'h00, 8'h00, 8'h00);
      send_beat(OPC_PIXEL, 8'h80, 8'h01, 8'hFE);
      // pixel while draining counts as a flush
      send_beat(OPC_PIXEL, 8'hFF, 8'hFF, 8'hFF);
      drain_frame();
   endtask

   task automatic test_register_extremes();
      write_reg(CSR_NORMAL_Z, 0);
      run_frame(0, 0, 1'b0);
      write_reg(CSR_NORMAL_Z, 65535);
      run_frame(1, 3, 1'b0);
      write_reg(CSR_NORMAL_Z, 1);
      run_frame(4, 2, 1'b0);
      // unknown index must leave everything alone
      write_reg(2'd3, 16'hFFFF);
      run_frame(1, 8191, 1'b1);
      run_frame(1, 4096, 1'b1);
      write_reg(CSR_NORMAL_Z, 765);
      run_frame(2047, 1, 1'b1);
      run_frame(1024, 2, 1'b1);
   endtask

   task automatic test_random_frames(int unsigned beats);
      int unsigned goal;
      goal = beats_sent + beats;
      while (beats_sent < goal) begin
         if ($urandom_range(0, 3) == 0) write_reg(CSR_NORMAL_Z, $urandom_range(0, 65535));
         run_frame($urandom_range(1, 10), $urandom_range(1, 6), $urandom_range(0, 9) == 0);
      end
   endtask

   // result side back-pressure in bursts
   int unsigned stall_left;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (quiet) begin
         rsp_ready <= 1'b1;
      end else if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(0, 16);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      normal_type want, got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.nx = rsp_normal_x_byte;
         got.ny = rsp_normal_y_byte;
         got.nz = rsp_normal_z_byte;
         got.col = rsp_out_col;
         got.row = rsp_out_row;
         got.done = rsp_frame_done;
         if (normals_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat x=%0d y=%0d z=%0d col=%0d row=%0d done=%0d",
                     $time, got.nx, got.ny, got.nz, got.col, got.row, got.done);
         end else begin
            want = normals_due.pop_front();
            normals_checked++;
            if (want != got) begin
               errors++;
               $display("%0t: mismatch expected x=%0d y=%0d z=%0d col=%0d row=%0d done=%0d",
                        $time, want.nx, want.ny, want.nz, want.col, want.row, want.done);
               $display("%0t:          actual   x=%0d y=%0d z=%0d col=%0d row=%0d done=%0d",
                        $time, got.nx, got.ny, got.nz, got.col, got.row, got.done);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("timeout after %0d cycles, %0d normals outstanding",
                  cycles, normals_due.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < 2 * LINE_MAX; i++) line_sums[i] = '0;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) win[i][j] = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_small_frame();
      test_register_extremes();
      test_random_frames(700);
      quiet = 1'b1;
      test_random_frames(100);
      req_valid <= 1'b0;
      while (normals_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      $display("sent %0d beats over %0d frames, %0d normals checked, %0d errors",
               beats_sent, frames_done, normals_checked, errors);
      $display("covered edge clamping, flush draining, saturated sizes and z extremes");
      if (errors == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule
